>>> hdl/cmbre_pkg.sv
package cmbre_pkg;

    localparam logic [15:0] PROB_HALF = 16'd32768;
    localparam logic [15:0] PROB_MAX  = 16'd65535;
    localparam logic [17:0] PR_MAX    = 18'd262143;
    localparam int          SSE_COLS  = 17;
    localparam int          SSE_DEPTH = 8704;
    localparam int          O0_DEPTH  = 256;
    localparam int          O1_DEPTH  = 65536;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_P,
        ST_RD2,
        ST_INT,
        ST_PR,
        ST_MID,
        ST_RENORM,
        ST_UPD1,
        ST_UPD2,
        ST_END,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic clr;          // clearing pass write
        logic start;        // take the input transaction
        logic rd1;          // read order-0 and both order-1 entries
        logic p_en;         // register mixed probability and sse base
        logic rd2;          // read the two sse entries
        logic prod_en;      // register interpolation product
        logic pr_en;        // register final probability
        logic mid_en;       // split the range
        logic renorm_shift; // move top byte to holding register
        logic out_hold;     // load output from holding register
        logic out_flush;    // load output from top byte of low
        logic out_last;     // last flag for the loaded byte
        logic upd1;         // write order-0, order-1 and first sse entry
        logic upd2;         // write second sse entry, step to next bit
        logic end_byte;     // update run count and history
        logic reset_regs;   // restore model state after flush
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic renorm_need;
        logic hold_v;
        logic out_busy;
        logic bit_last;
        logic cnt_three;
    } t_sts;

    function automatic logic [15:0] adapt(input logic [15:0] v, input logic b,
                                          input int unsigned rate);
        logic [15:0] r;
        if (b) begin
            r = v + ((PROB_MAX - v) >> rate);
        end else begin
            r = v - (v >> rate);
        end
        return r;
    endfunction

endpackage

>>> hdl/cmbre_ctrl.sv
module cmbre_ctrl
    import cmbre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_op ? ST_FLUSH : ST_RD1;
                end
            end
            ST_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state = ST_P;
            end
            ST_P: begin
                o_cmd.p_en = 1'b1;
                n_state = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state = ST_INT;
            end
            ST_INT: begin
                o_cmd.prod_en = 1'b1;
                n_state = ST_PR;
            end
            ST_PR: begin
                o_cmd.pr_en = 1'b1;
                n_state = ST_MID;
            end
            ST_MID: begin
                o_cmd.mid_en = 1'b1;
                n_state = ST_RENORM;
            end
            ST_RENORM: begin
                if (i_sts.renorm_need) begin
                    if (!(i_sts.hold_v && i_sts.out_busy)) begin
                        o_cmd.renorm_shift = 1'b1;
                        o_cmd.out_hold = i_sts.hold_v;
                    end
                end else begin
                    n_state = ST_UPD1;
                end
            end
            ST_UPD1: begin
                o_cmd.upd1 = 1'b1;
                n_state = ST_UPD2;
            end
            ST_UPD2: begin
                o_cmd.upd2 = 1'b1;
                n_state = i_sts.bit_last ? ST_END : ST_RD1;
            end
            ST_END: begin
                if (!i_sts.hold_v) begin
                    o_cmd.end_byte = 1'b1;
                    n_state = ST_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.out_hold = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.end_byte = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_flush = 1'b1;
                    o_cmd.out_last = i_sts.cnt_three;
                    if (i_sts.cnt_three) begin
                        o_cmd.reset_regs = 1'b1;
                        n_state = ST_CLEAR;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.reset_regs |=> (r_state == ST_CLEAR))
        else $error("flush did not start clearing pass");

    a_bit_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MID) |=> (r_state == ST_RENORM))
        else $error("range split not followed by renormalization");

endmodule

>>> hdl/cmbre_dpath.sv
module cmbre_dpath
    import cmbre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_ready,
    output t_sts       o_sts,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [15:0] mem_o0 [O0_DEPTH];
    logic [15:0] mem_o1 [O1_DEPTH];
    logic [15:0] mem_sse [SSE_DEPTH];

    logic [7:0]  r_sym;
    logic [7:0]  r_ctx;
    logic [2:0]  r_bit;
    logic        r_flag;
    logic [7:0]  r_prev;
    logic [7:0]  r_prev2;
    logic [1:0]  r_run;
    logic [31:0] r_low;
    logic [31:0] r_high;
    logic [15:0] r_o0q;
    logic [15:0] r_o1aq;
    logic [15:0] r_o1bq;
    logic [15:0] r_p;
    logic [13:0] r_base;
    logic [15:0] r_x0;
    logic [15:0] r_x1;
    logic signed [29:0] r_prod;
    logic [17:0] r_pr;
    logic [7:0]  r_hold;
    logic        r_hold_v;
    logic        r_out_v;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [15:0] r_clr_cnt;
    logic [4:0]  r_clr_col;

    logic        bitval;
    logic [19:0] mix_sum;
    logic [15:0] p_next;
    logic [8:0]  row;
    logic [13:0] base_next;
    logic [13:0] base_p1;
    logic signed [16:0] diff;
    logic signed [17:0] interp;
    logic signed [21:0] pr_wide;
    logic [17:0] pr_next;
    logic [49:0] range_prod;
    logic [31:0] mid;
    logic        out_load;
    logic        out_busy;
    logic        sse_clr_we;
    logic [15:0] sse_clr_val;

    assign bitval  = r_sym[3'd7 - r_bit];
    assign mix_sum = (({4'b0, r_o0q} + {4'b0, r_o1aq}) * 20'd7) + {3'b0, r_o1bq, 1'b0};
    assign p_next  = mix_sum[19:4];
    assign row     = {r_ctx, r_flag};
    assign base_next = {1'b0, row, 4'b0} + {5'b0, row} + {10'b0, p_next[15:12]};
    assign base_p1 = r_base + 14'd1;
    assign diff    = $signed({1'b0, r_x1}) - $signed({1'b0, r_x0});
    assign interp  = 18'(r_prod >>> 12);
    assign pr_wide = (($signed({6'b0, r_x0}) + 22'(interp)) * 22'sd3)
                     + $signed({6'b0, r_p});
    always_comb begin
        if (pr_wide < 22'sd1) begin
            pr_next = 18'd1;
        end else if (pr_wide > $signed({4'b0, PR_MAX})) begin
            pr_next = PR_MAX;
        end else begin
            pr_next = pr_wide[17:0];
        end
    end
    assign range_prod = {18'b0, r_high - r_low} * {32'b0, r_pr};
    assign mid        = r_low + range_prod[49:18];

    assign out_busy = r_out_v && !i_ready;
    assign out_load = i_cmd.out_hold || i_cmd.out_flush;

    assign sse_clr_we  = i_cmd.clr && (32'(r_clr_cnt) < SSE_DEPTH);
    assign sse_clr_val = (r_clr_col == 5'd16) ? PROB_MAX : {r_clr_col[3:0], 12'b0};

    // tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_o0[r_clr_cnt[7:0]] <= PROB_HALF;
        end else if (i_cmd.upd1) begin
            mem_o0[r_ctx] <= adapt(r_o0q, bitval, 2);
        end
        if (i_cmd.rd1) begin
            r_o0q <= mem_o0[r_ctx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_o1[r_clr_cnt] <= PROB_HALF;
        end else if (i_cmd.upd1) begin
            mem_o1[{r_prev, r_ctx}] <= adapt(r_o1aq, bitval, 4);
        end
        if (i_cmd.rd1) begin
            r_o1aq <= mem_o1[{r_prev, r_ctx}];
            r_o1bq <= mem_o1[{r_prev2, r_ctx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sse_clr_we) begin
            mem_sse[r_clr_cnt[13:0]] <= sse_clr_val;
        end else if (i_cmd.upd1) begin
            mem_sse[r_base] <= adapt(r_x0, bitval, 6);
        end else if (i_cmd.upd2) begin
            mem_sse[base_p1] <= adapt(r_x1, bitval, 6);
        end
        if (i_cmd.rd2) begin
            r_x0 <= mem_sse[r_base];
            r_x1 <= mem_sse[base_p1];
        end
    end

    // arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.p_en) begin
            r_p    <= p_next;
            r_base <= base_next;
        end
        if (i_cmd.prod_en) begin
            r_prod <= 30'(diff) * $signed({18'b0, r_p[11:0]});
        end
        if (i_cmd.pr_en) begin
            r_pr <= pr_next;
        end
        if (i_cmd.start) begin
            r_sym <= i_data_byte;
        end
    end

    // model and coder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_regs) begin
            r_prev    <= '0;
            r_prev2   <= '0;
            r_run     <= '0;
            r_low     <= '0;
            r_high    <= 32'hFFFF_FFFF;
            r_clr_cnt <= '0;
            r_clr_col <= '0;
            r_hold_v  <= 1'b0;
            r_ctx     <= 8'd1;
            r_bit     <= '0;
            r_flag    <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 16'd1;
                r_clr_col <= (r_clr_col == 5'd16) ? 5'd0 : r_clr_col + 5'd1;
            end
            if (i_cmd.start) begin
                r_ctx  <= 8'd1;
                r_bit  <= '0;
                r_flag <= (r_run == 2'd3);
            end
            if (i_cmd.mid_en) begin
                if (bitval) begin
                    r_high <= mid;
                end else begin
                    r_low <= mid + 32'd1;
                end
            end
            if (i_cmd.renorm_shift) begin
                r_hold   <= r_low[31:24];
                r_hold_v <= 1'b1;
                r_low    <= {r_low[23:0], 8'h00};
                r_high   <= {r_high[23:0], 8'hFF};
            end else if (i_cmd.out_hold) begin
                r_hold_v <= 1'b0;
            end
            if (i_cmd.out_flush) begin
                r_low <= {r_low[23:0], 8'h00};
                r_bit <= r_bit + 3'd1;
            end
            if (i_cmd.upd2) begin
                r_ctx <= {r_ctx[6:0], bitval};
                r_bit <= r_bit + 3'd1;
            end
            if (i_cmd.end_byte) begin
                if (r_sym == r_prev) begin
                    r_run <= (r_run == 2'd3) ? 2'd3 : r_run + 2'd1;
                end else begin
                    r_run <= '0;
                end
                r_prev2 <= r_prev;
                r_prev  <= r_sym;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= i_cmd.out_flush ? r_low[31:24] : r_hold;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    assign o_sts.clr_done    = (r_clr_cnt == 16'hFFFF);
    assign o_sts.renorm_need = ((r_low[31:24] ^ r_high[31:24]) == 8'h00);
    assign o_sts.hold_v      = r_hold_v;
    assign o_sts.out_busy    = out_busy;
    assign o_sts.bit_last    = (r_bit == 3'd7);
    assign o_sts.cnt_three   = (r_bit == 3'd3);

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !out_busy)
        else $error("output byte overwritten before transaction");

    a_hold_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.renorm_shift && r_hold_v) |-> i_cmd.out_hold)
        else $error("held byte lost on renormalization");

    a_pr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pr_en |=> (r_pr != 18'd0))
        else $error("coding probability out of range");

endmodule

>>> hdl/cm_binary_range_encoder.sv
// context-mixing binary range encoder: one input transaction carries a byte to code
// (op = 0) or a flush (op = 1). each of the eight bits, msb first, runs through these steps:
// two table reads, mixing, sse interpolation, the 32x18 range split, then table write-back
// in two steps, plus a renormalization step for each emitted byte. no new input is taken
// until the last bit of the current byte is done, and the block waits while the output
// stalls. the bit loop is set by the single write port of each table and the serial
// dependence of each bit on the previous update. bytes come out in order on the output
// channel, with last set on the final byte of the transaction; a byte that yields no
// output gives no transaction. a flush emits the four bytes of low, then a clearing pass
// restores every table, during which no input is taken; the same pass runs after reset.
module cm_binary_range_encoder
    import cmbre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clearing pass, per-bit steps, renormalization and flush
    cmbre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    // datapath: probability tables, mixer, sse, range coder and output register
    cmbre_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .i_ready     (i_ready),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

>>> bench/tb_cm_binary_range_encoder.sv
`timescale 1ns / 100ps

module tb_cm_binary_range_encoder;
    import cmbre_pkg::*;

    localparam int ITEM_TARGET   = 450;
    localparam int FLUSH_BUDGET  = 4;       // random flushes, each costs a full clearing pass
    localparam int IDLE_LIMIT    = 200000;  // covers a clearing pass plus the long stall, with margin
    localparam int DRAIN_CYCLES  = 300;
    localparam logic OP_CODE     = 1'b0;
    localparam logic OP_FLUSH    = 1'b1;

    // scoreboard: carries its own copy of the coder and model tables
    class cm_coder_scoreboard;
        logic [15:0] o0_tab [256];
        logic [15:0] o1_tab [65536];
        logic [15:0] sse_tab [8704];
        logic [7:0]  last_sym, last2_sym;
        logic [1:0]  repeats;
        logic [31:0] lo, hi;
        logic [8:0]  byte_q [$];   // {last, out_byte}
        int          errors;

        function new();
            errors = 0;
            restore();
        endfunction

        function void restore();
            for (int i = 0; i < 256; i++) o0_tab[i] = PROB_HALF;
            for (int i = 0; i < 65536; i++) o1_tab[i] = PROB_HALF;
            for (int r = 0; r < 512; r++)
                for (int k = 0; k < SSE_COLS; k++)
                    sse_tab[r*SSE_COLS+k] = (k == 16) ? PROB_MAX : 16'(k << 12);
            last_sym = '0;
            last2_sym = '0;
            repeats = '0;
            lo = '0;
            hi = 32'hFFFF_FFFF;
        endfunction

        function void stash_byte(logic [8:0] v);
            byte_q = {byte_q, v};
        endfunction

        function logic [15:0] shift_rate(logic [15:0] v, logic b, int rate);
            return b ? 16'(v + ((16'hFFFF - v) >> rate)) : 16'(v - (v >> rate));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // works out the output bytes of one accepted input transaction
        function void note_input(logic op, logic [7:0] sym);
            int          n0, ctx, a1, a2, col, base, x0, x1, interp, pr;
            logic [31:0] mix, mid;
            logic [63:0] span;
            logic        b, flag;
            n0 = byte_q.size();
            if (op == OP_FLUSH) begin
                for (int i = 0; i < 4; i++) begin
                    stash_byte({1'b0, lo[31:24]});
                    lo = lo << 8;
                end
                byte_q[$][8] = 1'b1;
                restore();
                return;
            end
            flag = (repeats == 2'd3);
            ctx = 1;
            for (int bi = 7; bi >= 0; bi--) begin
                b = sym[bi];
                a1 = int'(last_sym) * 256 + ctx;
                a2 = int'(last2_sym) * 256 + ctx;
                mix = ((32'(o0_tab[ctx]) + 32'(o1_tab[a1])) * 7 + 2 * 32'(o1_tab[a2])) >> 4;
                col = int'(mix >> 12);
                base = (2 * ctx + int'(flag)) * SSE_COLS + col;
                x0 = int'(sse_tab[base]);
                x1 = int'(sse_tab[base + 1]);
                interp = ((x1 - x0) * int'(mix & 32'hFFF)) >>> 12;  // floor
                pr = (x0 + interp) * 3 + int'(mix);
                if (pr < 1) pr = 1;
                else if (pr > 262143) pr = 262143;
                span = 64'(hi - lo) * 64'(pr);
                mid = lo + 32'(span >> 18);
                if (b) hi = mid;
                else lo = mid + 32'd1;
                while ((lo ^ hi) < 32'h0100_0000) begin
                    stash_byte({1'b0, lo[31:24]});
                    lo = lo << 8;
                    hi = (hi << 8) | 32'hFF;
                end
                o0_tab[ctx] = shift_rate(o0_tab[ctx], b, 2);
                o1_tab[a1] = shift_rate(o1_tab[a1], b, 4);
                sse_tab[base] = shift_rate(sse_tab[base], b, 6);
                sse_tab[base+1] = shift_rate(sse_tab[base+1], b, 6);
                ctx = (ctx * 2 + int'(b)) & 255;
            end
            if (sym == last_sym) repeats = (repeats == 2'd3) ? 2'd3 : repeats + 2'd1;
            else repeats = '0;
            last2_sym = last_sym;
            last_sym = sym;
            if (byte_q.size() > n0) byte_q[$][8] = 1'b1;
        endfunction

        task check_result(logic [7:0] got_byte, logic got_last);
            logic [8:0] want;
            if (byte_q.size() == 0) begin
                report($sformatf("unexpected output byte %02h last %0b", got_byte, got_last));
                return;
            end
            want = byte_q.pop_front();
            if (got_byte !== want[7:0])
                report($sformatf("out_byte %02h, expected %02h", got_byte, want[7:0]));
            if (got_last !== want[8])
                report($sformatf("last %0b, expected %0b", got_last, want[8]));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_op = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready, o_valid, o_last;
    logic [7:0] o_out_byte;

    cm_coder_scoreboard sb = new();
    int  sent = 0;
    int  idle_cycles = 0;
    bit  hold_request = 1'b0;   // ask the receiver for its long hold-off

    cm_binary_range_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side: compare every accepted byte with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_out_byte, o_last);
        end
    end

    // receiver stall pattern: free-running, random, mostly-stalled phases,
    // plus one long hold-off on request while the sender keeps offering
    initial begin
        int mode, len, hold;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 0;
                while (hold < 600) begin
                    @(posedge i_clk);
                    i_ready <= 1'b0;
                    hold++;
                end
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(5, 120);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d bytes outstanding", sb.byte_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one transaction and hold it until accepted; valid stays high for the burst
    task send_item(logic op, logic [7:0] sym, bit end_of_burst);
        i_valid <= 1'b1;
        i_op <= op;
        i_data_byte <= sym;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, sym);
        sent++;
        if (end_of_burst) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [7:0] sym;
        logic [7:0] alphabet [8];
        int         burst, flushes, pick;
        alphabet = '{8'h20, 8'h61, 8'h65, 8'h74, 8'h6F, 8'h0A, 8'h2E, 8'h73};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: flush of a fresh coder, field extremes, a run long enough
        // to switch the sse rows, alternating patterns, then flush again and code one more byte
        send_item(OP_FLUSH, 8'hFF, 1'b1);
        send_item(OP_CODE, 8'h00, 1'b0);
        send_item(OP_CODE, 8'hFF, 1'b1);
        for (int i = 0; i < 7; i++) send_item(OP_CODE, 8'h41, i == 6);
        send_item(OP_CODE, 8'h55, 1'b0);
        send_item(OP_CODE, 8'hAA, 1'b0);
        send_item(OP_CODE, 8'h55, 1'b0);
        send_item(OP_CODE, 8'h80, 1'b0);
        send_item(OP_CODE, 8'h01, 1'b1);
        for (int i = 0; i < 5; i++) send_item(OP_CODE, 8'h00, 1'b0);
        send_item(OP_FLUSH, 8'h00, 1'b1);
        send_item(OP_CODE, 8'h7F, 1'b1);

        // random: mostly text-like data with runs, some noise, rare flushes
        flushes = 0;
        burst = $urandom_range(1, 12);
        while (sent < ITEM_TARGET) begin
            if (sent == 120) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            burst--;
            if (pick == 0 && flushes < FLUSH_BUDGET && sent > 150) begin
                flushes++;
                send_item(OP_FLUSH, 8'($urandom), 1'b1);
            end else begin
                if (pick < 40) sym = sb.last_sym;
                else if (pick < 75) sym = alphabet[3'($urandom_range(0, 7))];
                else sym = 8'($urandom);
                send_item(OP_CODE, sym, burst <= 0);
            end
            if (burst <= 0) burst = $urandom_range(1, 12);
        end
        i_valid <= 1'b0;

        while (sb.byte_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cmbre_pkg.sv
hdl/cmbre_ctrl.sv
hdl/cmbre_dpath.sv
hdl/cm_binary_range_encoder.sv
bench/tb_cm_binary_range_encoder.sv
